### hw/rtl/vwdsd_pkg.sv
// shared constants and helpers for the variable width delta sample decoder
package vwdsd_pkg;

  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned BUF_BITS    = 16;
  localparam int unsigned HELD_BITS   = 5;
  localparam int unsigned WIDTH_BITS  = 4;
  localparam int unsigned COUNT_BITS  = 3;
  localparam int unsigned MAX_OUT     = 4;

  localparam logic [WIDTH_BITS-1:0] CODE_BITS    = 4'd3;
  localparam logic [WIDTH_BITS-1:0] WIDTH_OFFSET = 4'd2;
  localparam logic [WIDTH_BITS-1:0] MAX_DELTA_W  = 4'd8;
  localparam logic [2:0]            FLIP_CODE    = 3'd7;  // sign flip code
  localparam logic [BYTE_BITS-1:0]  SIGN_FLIP    = 8'h80;

  // header phase codes
  localparam logic [1:0] PH_COUNT_LO = 2'd0;
  localparam logic [1:0] PH_COUNT_HI = 2'd1;
  localparam logic [1:0] PH_FIRST    = 2'd2;
  localparam logic [1:0] PH_PAYLOAD  = 2'd3;

  // ones in the low n bits, n up to sixteen
  function automatic logic [BUF_BITS-1:0] low_mask(input logic [HELD_BITS-1:0] n);
    logic [BUF_BITS:0] t;
    t = ({{BUF_BITS{1'b0}}, 1'b1} << n) - {{BUF_BITS{1'b0}}, 1'b1};
    return t[BUF_BITS-1:0];
  endfunction

endpackage

### hw/rtl/variable_width_delta_sample_decoder_unit.sv
// top level of the variable width delta sample decoder
//
// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid_i/tready_o      tdata: byte_in, tuser: start_req
// m_axis    out        m_axis_tvalid_o/tready_i      tdata: sample_out, tlast: last
// cfg       in         cfg_valid_i/cfg_ready_o       data: msb_first
//
// a header byte is consumed in the cycle of its transaction
// the first-sample byte passes to a state that loads the output register once it is free
// a payload byte is followed by k extractor steps, k the number of codes and deltas taken from
// the bit buffer (at most seven), set by the single shared bit extractor
// reset clears the decode state and sets the bit order to lsb first
// a result waiting in the output register stalls the extractor only when the
// next step would produce another sample; the input side stays closed meanwhile
// the configuration channel opens only between bytes and holds the input back
// while its valid is high
module variable_width_delta_sample_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] byte_in
  input  logic       s_axis_tuser_i,   // [0] start_req
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] sample_out
  output logic       m_axis_tlast_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i        // msb_first
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_RUN
  } state_e;

  state_e                            state_q;
  logic [1:0]                        phase_q;
  logic [15:0]                       left_q;
  logic [7:0]                        cur_q;
  logic [vwdsd_pkg::BUF_BITS-1:0]    buf_q;
  logic [vwdsd_pkg::HELD_BITS-1:0]   held_q;
  logic [vwdsd_pkg::WIDTH_BITS-1:0]  width_q;
  logic [vwdsd_pkg::COUNT_BITS-1:0]  count_q;
  logic                              msb_q;
  logic                              m_valid_q;
  logic [7:0]                        m_data_q;
  logic                              m_last_q;

  logic s_accept;
  logic out_free;

  // bit order only changes between bytes, ahead of any waiting input
  assign s_axis_tready_o = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o     = (state_q == ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  // byte append into the bit buffer
  logic [vwdsd_pkg::HELD_BITS-1:0] held_a;
  logic [vwdsd_pkg::BUF_BITS-1:0]  buf_a;
  logic [vwdsd_pkg::BUF_BITS-1:0]  buf_add;

  always_comb begin
    if (held_q > 5'd8) begin
      held_a = 5'd8;
      buf_a  = {8'h00, buf_q[7:0]};
    end else begin
      held_a = held_q;
      buf_a  = buf_q;
    end
    if (msb_q) begin
      buf_add = {buf_a[7:0], s_axis_tdata_i};
    end else begin
      buf_add = buf_a | ({8'h00, s_axis_tdata_i} << held_a);
    end
  end

  // shared extractor: one code or delta per cycle, unless a waiting result stalls a step that emits
  logic [vwdsd_pkg::WIDTH_BITS-1:0] need;
  logic [vwdsd_pkg::HELD_BITS-1:0]  need_h;
  logic [vwdsd_pkg::HELD_BITS-1:0]  rem;
  logic                             enough;
  logic [vwdsd_pkg::BUF_BITS-1:0]   field16;
  logic [vwdsd_pkg::BUF_BITS-1:0]   buf_take;
  logic [vwdsd_pkg::BUF_BITS-1:0]   wmask;
  logic [7:0]                       field;
  logic [7:0]                       sign8;
  logic [7:0]                       ext;
  logic [7:0]                       next_sample;
  logic [vwdsd_pkg::WIDTH_BITS-1:0] next_width;
  logic                             will_emit;
  logic                             run_done;
  logic [15:0]                      left_dec;

  always_comb begin
    need     = (width_q == '0) ? vwdsd_pkg::CODE_BITS : width_q;
    need_h   = {1'b0, need};
    enough   = (held_q >= need_h);
    rem      = held_q - need_h;
    wmask    = vwdsd_pkg::low_mask({1'b0, width_q});
    if (msb_q) begin
      field16  = (buf_q >> rem) & vwdsd_pkg::low_mask(need_h);
      buf_take = buf_q & vwdsd_pkg::low_mask(rem);
    end else begin
      field16  = buf_q & vwdsd_pkg::low_mask(need_h);
      buf_take = buf_q >> need_h;
    end
    field    = field16[7:0];
    sign8    = 8'd0;
    ext      = field;
    next_sample = cur_q;
    next_width  = width_q;
    will_emit   = 1'b0;
    if (width_q == '0) begin
      if (field[2:0] == vwdsd_pkg::FLIP_CODE) begin
        next_sample = cur_q ^ vwdsd_pkg::SIGN_FLIP;
        will_emit   = 1'b1;
      end else begin
        next_width = {1'b0, field[2:0]} + vwdsd_pkg::WIDTH_OFFSET;
      end
    end else begin
      sign8 = 8'(9'd1 << (width_q - 4'd1));
      if (field == sign8) begin
        next_width = '0;   // terminator ends the run
      end else begin
        if ((field & sign8) != 8'd0) begin
          ext = field | ~wmask[7:0];
        end
        next_sample = cur_q + ext;
        will_emit   = 1'b1;
      end
    end
    left_dec = left_q - 16'd1;
    run_done = (left_q == 16'd0) ||
               (count_q == vwdsd_pkg::COUNT_BITS'(vwdsd_pkg::MAX_OUT)) || !enough;
  end

  // a sample enters the output register this cycle
  logic emit_now;

  assign emit_now = ((state_q == ST_FIRST) && out_free) ||
                    ((state_q == ST_RUN) && !run_done && will_emit && out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= vwdsd_pkg::PH_COUNT_LO;
      left_q    <= '0;
      cur_q     <= '0;
      buf_q     <= '0;
      held_q    <= '0;
      width_q   <= '0;
      count_q   <= '0;
      msb_q     <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_last_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        msb_q <= cfg_data_i;
      end
      if (emit_now) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            if (s_axis_tuser_i) begin
              // start of a new stream: sample, count and bit buffer state cleared, byte is count low
              phase_q <= vwdsd_pkg::PH_COUNT_HI;
              left_q  <= {8'h00, s_axis_tdata_i};
              cur_q   <= '0;
              buf_q   <= '0;
              held_q  <= '0;
              width_q <= '0;
            end else begin
              case (phase_q)
                vwdsd_pkg::PH_COUNT_LO: begin
                  left_q  <= {8'h00, s_axis_tdata_i};
                  phase_q <= vwdsd_pkg::PH_COUNT_HI;
                end
                vwdsd_pkg::PH_COUNT_HI: begin
                  left_q  <= {s_axis_tdata_i, left_q[7:0]};
                  phase_q <= vwdsd_pkg::PH_FIRST;
                end
                vwdsd_pkg::PH_FIRST: begin
                  phase_q <= vwdsd_pkg::PH_PAYLOAD;
                  buf_q   <= '0;
                  held_q  <= '0;
                  width_q <= '0;
                  if (left_q != 16'd0) begin
                    cur_q   <= s_axis_tdata_i;
                    state_q <= ST_FIRST;
                  end
                end
                default: begin
                  // payload: ignored once the count is reached
                  if (left_q != 16'd0) begin
                    buf_q   <= buf_add;
                    held_q  <= held_a + 5'd8;
                    count_q <= '0;
                    state_q <= ST_RUN;
                  end
                end
              endcase
            end
          end
        end
        ST_FIRST: begin
          if (out_free) begin
            m_data_q  <= cur_q;
            m_last_q  <= (left_dec == 16'd0);
            left_q    <= left_dec;
            state_q   <= ST_IDLE;
          end
        end
        ST_RUN: begin
          if (run_done) begin
            if (left_q == 16'd0) begin
              buf_q   <= '0;
              held_q  <= '0;
              width_q <= '0;
            end
            state_q <= ST_IDLE;
          end else if (!will_emit || out_free) begin
            buf_q   <= buf_take;
            held_q  <= rem;
            width_q <= next_width;
            cur_q   <= next_sample;
            if (will_emit) begin
              m_data_q  <= next_sample;
              m_last_q  <= (left_dec == 16'd0);
              left_q    <= left_dec;
              count_q   <= count_q + 3'd1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_first_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIRST) |-> (left_q != 16'd0))
    else $error("first sample pending with zero count");

  a_run_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (phase_q == vwdsd_pkg::PH_PAYLOAD))
    else $error("extractor running outside payload phase");

  a_width_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (width_q == '0) || ((width_q >= vwdsd_pkg::WIDTH_OFFSET) &&
                        (width_q <= vwdsd_pkg::MAX_DELTA_W)))
    else $error("illegal delta width");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (count_q <= vwdsd_pkg::COUNT_BITS'(vwdsd_pkg::MAX_OUT)))
    else $error("too many samples from one byte");

  a_emit_decrements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && !run_done && will_emit && out_free) |=>
      (left_q == $past(left_q) - 16'd1))
    else $error("sample emitted without count update");
`endif

endmodule
